### rtl/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

    // Default depth of the result queue; must be at least 2.
    localparam int ESD_QUEUE_DEPTH = 4;

    // Decoder mode between bytes.
    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_HEX2 = 3'd3,
        MODE_OCT1 = 3'd4,
        MODE_OCT2 = 3'd5
    } t_mode;

    // One result item as it travels to the output port.
    typedef struct packed {
        logic [7:0] code;
        logic       malformed;
        logic       final_res;
        logic       last;
    } t_res;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_LOWER_X   = 8'd120;

    // Values of the simple escapes.
    localparam logic [7:0] ESC_BELL      = 8'd7;
    localparam logic [7:0] ESC_BACKSPACE = 8'd8;
    localparam logic [7:0] ESC_TAB       = 8'd9;
    localparam logic [7:0] ESC_NEWLINE   = 8'd10;
    localparam logic [7:0] ESC_VTAB      = 8'd11;
    localparam logic [7:0] ESC_FORMFEED  = 8'd12;
    localparam logic [7:0] ESC_RETURN    = 8'd13;
    localparam logic [7:0] ESC_QUESTION  = 8'd63;
    localparam logic [7:0] ESC_DQUOTE    = 8'd34;
    localparam logic [7:0] ESC_SQUOTE    = 8'd39;

endpackage

### rtl/esd_decode.sv
`timescale 1ns / 1ps

module esd_decode
    import esd_pkg::*;
(
    input  t_mode      i_mode,
    input  logic [7:0] i_accum,
    input  logic [7:0] i_char_in,
    input  logic       i_end_mark,
    output t_res       o_res0,
    output t_res       o_res1,
    output logic [1:0] o_count,
    output t_mode      o_mode,
    output logic [7:0] o_accum
);

    // Map a simple escape letter to its value; bit 8 flags a hit.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        begin
            r = 9'd0;
            case (c)
                8'd97:  r = {1'b1, ESC_BELL};      // a
                8'd98:  r = {1'b1, ESC_BACKSPACE}; // b
                8'd116: r = {1'b1, ESC_TAB};       // t
                8'd110: r = {1'b1, ESC_NEWLINE};   // n
                8'd118: r = {1'b1, ESC_VTAB};      // v
                8'd102: r = {1'b1, ESC_FORMFEED};  // f
                8'd114: r = {1'b1, ESC_RETURN};    // r
                8'd63:  r = {1'b1, ESC_QUESTION};
                8'd34:  r = {1'b1, ESC_DQUOTE};
                8'd39:  r = {1'b1, ESC_SQUOTE};
                8'd92:  r = {1'b1, CH_BACKSLASH};
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Hex digit value in either case; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'd48 && c <= 8'd57) begin
                r = {1'b1, 4'(c - 8'd48)};
            end else if (c >= 8'd65 && c <= 8'd70) begin
                r = {1'b1, 4'(c - 8'd55)};
            end else if (c >= 8'd97 && c <= 8'd102) begin
                r = {1'b1, 4'(c - 8'd87)};
            end
            return r;
        end
    endfunction

    logic [8:0] esc;
    logic [4:0] hex;
    logic       is_oct;
    logic [2:0] oct_val;
    logic [7:0] oct_acc;
    t_res       r0;
    t_res       r1;
    logic [1:0] cnt;
    t_mode      nm;
    logic [7:0] na;

    assign esc     = simple_escape(i_char_in);
    assign hex     = hex_digit(i_char_in);
    assign is_oct  = (i_char_in[7:3] == 5'b00110);
    assign oct_val = i_char_in[2:0];
    assign oct_acc = {i_accum[4:0], oct_val};

    always_comb begin
        r0  = '0;
        r1  = '0;
        cnt = 2'd0;
        nm  = i_mode;
        na  = i_accum;
        if (i_end_mark) begin
            // Flush a pending escape, then the end marker.
            unique case (i_mode)
                MODE_ESC: begin
                    r0.malformed = 1'b1;
                    cnt = 2'd1;
                end
                MODE_HEX1, MODE_HEX2: begin
                    r0.code      = i_accum;
                    r0.malformed = 1'b1;
                    cnt = 2'd1;
                end
                MODE_OCT1, MODE_OCT2: begin
                    r0.code = i_accum;
                    cnt = 2'd1;
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
            if (cnt == 2'd1) begin
                r1.final_res = 1'b1;
                cnt = 2'd2;
            end else begin
                r0.final_res = 1'b1;
                cnt = 2'd1;
            end
            nm = MODE_TEXT;
        end else begin
            unique case (i_mode)
                MODE_ESC: begin
                    if (esc[8]) begin
                        r0.code = esc[7:0];
                        cnt = 2'd1;
                        nm  = MODE_TEXT;
                    end else if (i_char_in == CH_LOWER_X) begin
                        na = 8'd0;
                        nm = MODE_HEX1;
                    end else if (is_oct) begin
                        na = {5'd0, oct_val};
                        nm = MODE_OCT1;
                    end else begin
                        r0.code      = i_char_in;
                        r0.malformed = 1'b1;
                        cnt = 2'd1;
                        nm  = MODE_TEXT;
                    end
                end
                MODE_HEX1, MODE_HEX2: begin
                    if (!hex[4]) begin
                        // Bad digit: emit what was gathered, then treat byte as text.
                        r0.code      = i_accum;
                        r0.malformed = 1'b1;
                        cnt = 2'd1;
                        if (i_char_in == CH_BACKSLASH) begin
                            nm = MODE_ESC;
                            na = 8'd0;
                        end else begin
                            r1.code = i_char_in;
                            cnt = 2'd2;
                            nm  = MODE_TEXT;
                        end
                    end else if (i_mode == MODE_HEX1) begin
                        na = {4'd0, hex[3:0]};
                        nm = MODE_HEX2;
                    end else begin
                        r0.code = {i_accum[3:0], hex[3:0]};
                        cnt = 2'd1;
                        nm  = MODE_TEXT;
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (is_oct) begin
                        na = oct_acc;
                        if (i_mode == MODE_OCT1) begin
                            nm = MODE_OCT2;
                        end else begin
                            r0.code = oct_acc;
                            cnt = 2'd1;
                            nm  = MODE_TEXT;
                        end
                    end else begin
                        // Short octal run: emit value, then treat byte as text.
                        r0.code = i_accum;
                        cnt = 2'd1;
                        if (i_char_in == CH_BACKSLASH) begin
                            nm = MODE_ESC;
                            na = 8'd0;
                        end else begin
                            r1.code = i_char_in;
                            cnt = 2'd2;
                            nm  = MODE_TEXT;
                        end
                    end
                end
                default: begin
                    if (i_char_in == CH_BACKSLASH) begin
                        nm = MODE_ESC;
                        na = 8'd0;
                    end else begin
                        r0.code = i_char_in;
                        cnt = 2'd1;
                        nm  = MODE_TEXT;
                    end
                end
            endcase
        end
        if (nm == MODE_TEXT) begin
            na = 8'd0;
        end
        r0.last = (cnt == 2'd1);
        r1.last = 1'b1;
    end

    assign o_res0  = r0;
    assign o_res1  = r1;
    assign o_count = cnt;
    assign o_mode  = nm;
    assign o_accum = na;

endmodule

### rtl/esd_outq.sv
`timescale 1ns / 1ps

module esd_outq
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_wr_count,
    input  t_res       i_wr0,
    input  t_res       i_wr1,
    output logic       o_room,
    output logic       o_valid,
    output t_res       o_data,
    input  logic       i_pop
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] RoomMax = CntW'(QUEUE_DEPTH - 2);

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        begin
            return (p == LastPtr) ? '0 : p + PtrW'(1);
        end
    endfunction

    t_res            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;
    logic [PtrW-1:0] wr_ptr1;
    logic            pop;

    assign wr_ptr1 = ptr_inc(r_wr_ptr);
    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= RoomMax);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_wr_count == 2'd1) begin
            n_wr_ptr = wr_ptr1;
        end else if (i_wr_count == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CntW'(i_wr_count) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[wr_ptr1] <= i_wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Writes only arrive when the room check passed.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_count != 2'd0) |-> (r_count <= RoomMax))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

### rtl/escape_sequence_decoder.sv
`timescale 1ns / 1ps

// C string-literal escape decoder. Feed the literal body one byte per request
// on the input channel; each decoded character comes out as one request on the
// output channel with its byte value, a malformed flag, and a last flag on the
// final result caused by that input byte. Plain bytes pass through, simple
// escapes (a b t n v f r ? " ' backslash) map to their control values, octal
// escapes take one to three digits modulo 256, and hex escapes take exactly
// two digits. A request with end_mark set flushes any pending escape and then
// emits one result with final_res set; decoder state returns to plain text.
// An input byte produces zero, one or two results. The block takes one byte
// per cycle while the queue has room: a byte is held in the input register,
// then decoded in a single pass into a small result queue (QUEUE_DEPTH
// entries), from which its first result is offered on the output. The input
// register advances only when the queue has room for two results, so the
// sustained rate is one byte per cycle as long as the consumer drains one
// result per cycle; a byte that yields two results leaves an extra result
// for the consumer to drain.

module escape_sequence_decoder
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_mark,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_code,
    output logic       o_malformed,
    output logic       o_final_res,
    output logic       o_last
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_end;
    logic       n_in_valid;

    // Decoder state held between bytes.
    t_mode      r_mode;
    logic [7:0] r_accum;

    // Decode results.
    t_res       dec_res0;
    t_res       dec_res1;
    logic [1:0] dec_count;
    t_mode      dec_mode;
    logic [7:0] dec_accum;

    logic       q_room;
    logic       q_valid;
    t_res       q_data;
    logic       fire;
    logic       in_take;
    logic [1:0] wr_count;

    // Advance the held byte once the queue can absorb two results.
    assign fire       = r_in_valid && q_room;
    assign o_in_ready = !r_in_valid || q_room;
    assign in_take    = i_in_valid && o_in_ready;
    assign wr_count   = fire ? dec_count : 2'd0;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_TEXT;
            r_accum    <= 8'd0;
        end else begin
            r_in_valid <= n_in_valid;
            if (fire) begin
                r_mode  <= dec_mode;
                r_accum <= dec_accum;
            end
        end
    end

    // Capture payload on accept; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_char_in;
            r_end  <= i_end_mark;
        end
    end

    esd_decode u_decode (
        .i_mode     (r_mode),
        .i_accum    (r_accum),
        .i_char_in  (r_char),
        .i_end_mark (r_end),
        .o_res0     (dec_res0),
        .o_res1     (dec_res1),
        .o_count    (dec_count),
        .o_mode     (dec_mode),
        .o_accum    (dec_accum)
    );

    esd_outq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (wr_count),
        .i_wr0      (dec_res0),
        .i_wr1      (dec_res1),
        .o_room     (q_room),
        .o_valid    (q_valid),
        .o_data     (q_data),
        .i_pop      (i_out_ready)
    );

    assign o_out_valid = q_valid;
    assign o_code      = q_data.code;
    assign o_malformed = q_data.malformed;
    assign o_final_res = q_data.final_res;
    assign o_last      = q_data.last;

    // An end request always leaves the decoder in plain text with a clear accumulator.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_end) |=> (r_mode == MODE_TEXT && r_accum == 8'd0))
        else $error("end request did not reset decoder state");

    // Every end request yields at least the final marker.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_end) |-> (dec_count != 2'd0))
        else $error("end request without marker");

    // A held byte is not lost while the queue lacks room for two results.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !q_room) |=> r_in_valid)
        else $error("held byte dropped");

    // Plain text never carries a pending accumulator.
    a_text_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_TEXT) |-> (r_accum == 8'd0))
        else $error("accumulator nonzero in text mode");

endmodule

### test/escape_sequence_decoder_check.sv
`timescale 1ns / 1ps

module escape_sequence_decoder_check
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_mark,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_code,
    input  logic       i_malformed,
    input  logic       i_final_res,
    input  logic       i_last,
    output int         o_errors,
    output int         o_outstanding,
    output int         o_results
);

    t_mode      dec_mode;
    logic [8:0] dec_accum;
    t_res       step_out[$];
    t_res       expected_codes[$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        o_results     = 0;
        dec_mode      = MODE_TEXT;
        dec_accum     = '0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: decode mismatch: %s", $time, what);
        o_errors++;
    endtask

    function automatic t_res make_res(input logic [7:0] code, input logic bad,
                                      input logic fin);
        t_res r;
        r.code      = code;
        r.malformed = bad;
        r.final_res = fin;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic int simple_value(input logic [7:0] c);
        case (c)
            "a":          return int'(ESC_BELL);
            "b":          return int'(ESC_BACKSPACE);
            "t":          return int'(ESC_TAB);
            "n":          return int'(ESC_NEWLINE);
            "v":          return int'(ESC_VTAB);
            "f":          return int'(ESC_FORMFEED);
            "r":          return int'(ESC_RETURN);
            "?":          return int'(ESC_QUESTION);
            "\"":         return int'(ESC_DQUOTE);
            "'":          return int'(ESC_SQUOTE);
            CH_BACKSLASH: return int'(CH_BACKSLASH);
            default:      return -1;
        endcase
    endfunction

    // Plain-text handling of one byte: backslash opens an escape.
    task automatic take_text(input logic [7:0] c);
        if (c == CH_BACKSLASH) begin
            dec_mode  = MODE_ESC;
            dec_accum = '0;
        end else begin
            dec_mode = MODE_TEXT;
            step_out.push_back(make_res(c, 1'b0, 1'b0));
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic e);
        int   hv;
        int   sv;
        t_res r;
        step_out.delete();
        if (e) begin
            case (dec_mode)
                MODE_ESC:             step_out.push_back(make_res(8'd0, 1'b1, 1'b0));
                MODE_HEX1, MODE_HEX2: step_out.push_back(make_res(dec_accum[7:0], 1'b1, 1'b0));
                MODE_OCT1, MODE_OCT2: step_out.push_back(make_res(dec_accum[7:0], 1'b0, 1'b0));
                default: ;
            endcase
            step_out.push_back(make_res(8'd0, 1'b0, 1'b1));
            dec_mode  = MODE_TEXT;
            dec_accum = '0;
        end else begin
            case (dec_mode)
                MODE_ESC: begin
                    sv = simple_value(c);
                    if (sv >= 0) begin
                        step_out.push_back(make_res(sv[7:0], 1'b0, 1'b0));
                        dec_mode = MODE_TEXT;
                    end else if (c == CH_LOWER_X) begin
                        dec_accum = '0;
                        dec_mode  = MODE_HEX1;
                    end else if (is_octal(c)) begin
                        dec_accum = {6'd0, c[2:0]};
                        dec_mode  = MODE_OCT1;
                    end else begin
                        step_out.push_back(make_res(c, 1'b1, 1'b0));
                        dec_mode = MODE_TEXT;
                    end
                end
                MODE_HEX1, MODE_HEX2: begin
                    hv = hex_digit(c);
                    if (hv < 0) begin
                        step_out.push_back(make_res(dec_accum[7:0], 1'b1, 1'b0));
                        take_text(c);
                    end else if (dec_mode == MODE_HEX1) begin
                        dec_accum = {5'd0, hv[3:0]};
                        dec_mode  = MODE_HEX2;
                    end else begin
                        dec_accum = {dec_accum[4:0], hv[3:0]};
                        step_out.push_back(make_res(dec_accum[7:0], 1'b0, 1'b0));
                        dec_mode = MODE_TEXT;
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (is_octal(c)) begin
                        // the shift drops the top three bits; the low eight bits give the value modulo 256
                        dec_accum = {dec_accum[5:0], c[2:0]};
                        if (dec_mode == MODE_OCT1) begin
                            dec_mode = MODE_OCT2;
                        end else begin
                            step_out.push_back(make_res(dec_accum[7:0], 1'b0, 1'b0));
                            dec_mode = MODE_TEXT;
                        end
                    end else begin
                        step_out.push_back(make_res(dec_accum[7:0], 1'b0, 1'b0));
                        take_text(c);
                    end
                end
                default: take_text(c);
            endcase
            if (dec_mode == MODE_TEXT) dec_accum = '0;
        end
        foreach (step_out[k]) begin
            r      = step_out[k];
            r.last = (k == step_out.size() - 1);
            expected_codes.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            dec_mode  = MODE_TEXT;
            dec_accum = '0;
            expected_codes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.code      = i_code;
                got.malformed = i_malformed;
                got.final_res = i_final_res;
                got.last      = i_last;
                o_results++;
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code=%0d mal=%b fin=%b last=%b",
                        got.code, got.malformed, got.final_res, got.last));
                end else begin
                    want = expected_codes.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "code %0d/%0d mal %b/%b fin %b/%b last %b/%b (got/want)",
                            got.code, want.code, got.malformed, want.malformed,
                            got.final_res, want.final_res, got.last, want.last));
                end
            end
            if (i_in_valid && i_in_ready)
                decode_byte(i_char_in, i_end_mark);
        end
        o_outstanding <= expected_codes.size();
    end

endmodule

### test/escape_sequence_decoder_test.sv
`timescale 1ns / 1ps

module escape_sequence_decoder_test;
    import esd_pkg::*;

    // Idle patterns for either side of the block.
    typedef enum int {
        PACE_FULL,
        PACE_RANDOM,
        PACE_SPARSE
    } t_pace;

    // Kinds of random text fragments.
    typedef enum int {
        FRAG_PLAIN,
        FRAG_SIMPLE,
        FRAG_OCTAL,
        FRAG_HEX,
        FRAG_UNKNOWN,
        FRAG_END,
        FRAG_NOISE
    } t_frag;

    localparam int RANDOM_REQUESTS = 1500;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_char_in = 8'd0;
    logic       i_end_mark = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_code;
    logic       o_malformed;
    logic       o_final_res;
    logic       o_last;

    int    error_count;
    int    outstanding;
    int    results_seen;
    int    sent_requests = 0;
    int    end_requests = 0;
    t_pace in_pace = PACE_FULL;
    t_pace out_pace = PACE_FULL;
    string simple_set = "abtnvfr?\"'\\";

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    escape_sequence_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_in   (i_char_in),
        .i_end_mark  (i_end_mark),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code      (o_code),
        .o_malformed (o_malformed),
        .o_final_res (o_final_res),
        .o_last      (o_last)
    );

    escape_sequence_decoder_check checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .i_end_mark    (i_end_mark),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_code        (o_code),
        .i_malformed   (o_malformed),
        .i_final_res   (o_final_res),
        .i_last        (o_last),
        .o_errors      (error_count),
        .o_outstanding (outstanding),
        .o_results     (results_seen)
    );

    // Draw the idle cycles before the next request on one side.
    function automatic int draw_gap(input t_pace pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 16);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    function automatic t_pace draw_pace();
        case ($urandom_range(0, 2))
            0:       return PACE_FULL;
            1:       return PACE_RANDOM;
            default: return PACE_SPARSE;
        endcase
    endfunction

    function automatic logic [7:0] octal_char();
        return "0" + 8'($urandom_range(0, 7));
    endfunction

    // Pick a hex digit in either letter case.
    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 10) return "0" + v;
        return ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
    endfunction

    function automatic t_frag draw_frag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return FRAG_PLAIN;
        if (r < 42) return FRAG_SIMPLE;
        if (r < 58) return FRAG_OCTAL;
        if (r < 74) return FRAG_HEX;
        if (r < 81) return FRAG_UNKNOWN;
        if (r < 90) return FRAG_END;
        return FRAG_NOISE;
    endfunction

    // Present one request and hold it until the block takes it. Lower valid
    // only when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input logic [7:0] c, input logic e);
        int gap;
        gap = draw_gap(in_pace);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        i_end_mark <= e;
        do @(posedge i_clk); while (!o_in_ready);
        sent_requests++;
        if (e) end_requests++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_request(s[k], 1'b0);
    endtask

    // Close the stream; the character byte is junk and must be ignored.
    task automatic send_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Send one random fragment: plain bytes, well-formed escapes with random
    // contents, truncated and malformed ones, or a stream end.
    task automatic send_fragment();
        int n;
        case (draw_frag())
            FRAG_PLAIN: begin
                n = $urandom_range(1, 6);
                repeat (n) send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            FRAG_SIMPLE: begin
                send_request(CH_BACKSLASH, 1'b0);
                send_request(simple_set[$urandom_range(0, simple_set.len() - 1)], 1'b0);
            end
            FRAG_OCTAL: begin
                send_request(CH_BACKSLASH, 1'b0);
                n = $urandom_range(1, 3);
                repeat (n) send_request(octal_char(), 1'b0);
                // cut a short run off with an arbitrary byte
                if (n < 3 || $urandom_range(0, 1))
                    send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            FRAG_HEX: begin
                send_request(CH_BACKSLASH, 1'b0);
                send_request(CH_LOWER_X, 1'b0);
                n = $urandom_range(0, 5);
                if (n >= 2) begin
                    send_request(hex_char(), 1'b0);
                    send_request(hex_char(), 1'b0);
                end else begin
                    if (n == 1) send_request(hex_char(), 1'b0);
                    send_request(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            FRAG_UNKNOWN: begin
                send_request(CH_BACKSLASH, 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            FRAG_END: begin
                // leave the decoder in text or some escape state, then close
                n = $urandom_range(0, 5);
                if (n >= 1) send_request(CH_BACKSLASH, 1'b0);
                if (n == 2 || n == 3) send_request(CH_LOWER_X, 1'b0);
                if (n == 3) send_request(hex_char(), 1'b0);
                if (n >= 4) send_request(octal_char(), 1'b0);
                if (n == 5) send_request(octal_char(), 1'b0);
                send_end();
            end
            default: send_request(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    // Result side: per result, hold ready low for a drawn stall, then raise
    // it and keep it up until a result is taken.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap(out_pace);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int random_start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, an end carrying a nonzero junk byte,
        // backslash-zero, octal wrap, both hex letter cases, an unknown
        // escape, a bad hex digit, a short octal run, and the three ways an
        // end can cut an escape off.
        send_request(8'd0, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd255, 1'b1);
        send_text("\\0\\777\\xFf\\q\\xg\\1z");
        send_text("\\");
        send_end();
        send_text("\\xa");
        send_end();
        send_text("\\7");
        send_end();

        // Random: reshuffle the idle patterns now and then so gaps land on
        // every phase of the decode, with stretches at full rate too.
        random_start = sent_requests;
        while (sent_requests - random_start < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 29) == 0) begin
                in_pace  = draw_pace();
                out_pace = draw_pace();
            end
            send_fragment();
        end
        send_end();
        i_in_valid <= 1'b0;

        // Drain: let the checker's count catch up with the last request first.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Decoded %0d input bytes including %0d stream ends.",
                 sent_requests, end_requests);
        $display("Checked %0d results across plain, simple, octal and hex escapes.",
                 results_seen);
        if (error_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Timeout waiting for the decoder");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
